/* sv/windowed_trend_slope_tracker_core_macros.svh */
// Assertion macros used by the slope tracker sequencer.
`ifndef WINDOWED_TREND_SLOPE_TRACKER_CORE_MACROS_SVH
`define WINDOWED_TREND_SLOPE_TRACKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset.
`define WTST_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check a consequence in the same cycle as its antecedent.
`define WTST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check a consequence in the cycle after its antecedent.
`define WTST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WTST_ASSERT_ALWAYS(label, expr, msg)
`define WTST_ASSERT_IMPL(label, ante, cons, msg)
`define WTST_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* sv/wtst_pkg.sv */
// Shared types, widths and constants of the slope tracker.
package wtst_pkg;

    localparam int HISTORY_DEPTH = 32;
    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SAMP_W = 16;
    localparam int NUM_CH = 3;
    localparam int CH_W = 2;
    localparam int SY_W = SAMP_W + CNT_W;
    localparam int SXY_W = SAMP_W + 2 * CNT_W;
    localparam int R12_W = CNT_W + 4;
    localparam int LM6_W = 2 * CNT_W + 3;
    localparam int LL_W = 2 * CNT_W;
    localparam int DEN_W = 4 * CNT_W;
    localparam int NUM_W = SXY_W + CNT_W + 6;
    localparam int QB = 18;
    localparam int Q_W = QB + 1;
    localparam int QK_W = $clog2(QB);
    localparam int DIV_W = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
    localparam int THR_W = 15;
    localparam logic [THR_W-1:0] THR_RESET = 15'd3277;
    localparam int CNT_OUT_W = 6;
    localparam int MIN_FIT = 2;
    localparam int MIN_SPLIT = 6;
    localparam int MAG_W = 18;
    localparam int RECIP_W = 16;
    localparam logic [RECIP_W-1:0] RECIP5 = 16'd52429;
    localparam int RECIP_SH = 18;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        FIT_FULL,
        FIT_EARLY,
        FIT_LATE
    } fit_grp_t;

    typedef struct packed {
        logic                     op;
        logic signed [SAMP_W-1:0] sample_valence;
        logic signed [SAMP_W-1:0] sample_arousal;
        logic signed [SAMP_W-1:0] sample_dominance;
    } cmd_t;

    typedef struct packed {
        logic signed [SAMP_W-1:0] valence_trend;
        logic signed [SAMP_W-1:0] arousal_trend;
        logic signed [SAMP_W-1:0] dominance_trend;
        logic signed [SAMP_W-1:0] overall_trend;
        logic                     trend_changed;
        logic [CNT_OUT_W-1:0]     sample_count;
    } res_t;

    typedef struct packed {
        logic             mem_we;
        logic [PTR_W-1:0] mem_waddr;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
        logic             acc_clr;
        logic             acc_en;
        logic [CNT_W-1:0] acc_pos;
        logic [CNT_W-1:0] mid;
        fit_grp_t         grp;
        logic [CH_W-1:0]  ch;
        logic [CNT_W-1:0] fit_len;
        logic             fit_a;
        logic             fit_b;
        logic             fit_c;
        logic             div_en;
        logic             div_last;
        logic [QK_W-1:0]  div_k;
        logic             fin1;
        logic             fin2;
        logic             fin3;
        logic             load_out;
        logic [CNT_W-1:0] count;
    } dp_cmd_t;

endpackage

/* sv/wtst_ctrl.sv */
// Sequencer of the slope tracker: history pointers, scan, fit and division steps.
`include "windowed_trend_slope_tracker_core_macros.svh"
module wtst_ctrl
    import wtst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  logic     cmd_op,
    output logic     res_valid,
    input  logic     res_ready,
    output dp_cmd_t  dpc
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIT_A,
        S_FIT_B,
        S_FIT_C,
        S_DIV,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             acc_v_reg, acc_v_next;
    logic [CNT_W-1:0] acc_pos_reg, acc_pos_next;
    fit_grp_t         grp_reg, grp_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic [QK_W-1:0]  k_reg, k_next;
    logic             res_valid_reg, res_valid_next;

    logic             accept;
    logic             full;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] cnt_new;

    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] ptr,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(HISTORY_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(HISTORY_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign full      = (cnt_reg == CNT_W'(HISTORY_DEPTH));
    assign mid       = cnt_reg >> 1;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        oldest_next    = oldest_reg;
        pos_next       = pos_reg;
        acc_v_next     = 1'b0;
        acc_pos_next   = pos_reg;
        grp_next       = grp_reg;
        ch_next        = ch_reg;
        k_next         = k_reg;
        res_valid_next = res_valid_reg && !res_ready;
        cnt_new        = cnt_reg;

        dpc           = '0;
        dpc.mem_waddr = full ? oldest_reg : wrap(oldest_reg, cnt_reg);
        dpc.rd_addr   = wrap(oldest_reg, pos_reg);
        dpc.acc_en    = acc_v_reg;
        dpc.acc_pos   = acc_pos_reg;
        dpc.mid       = mid;
        dpc.grp       = grp_reg;
        dpc.ch        = ch_reg;
        dpc.div_k     = k_reg;
        dpc.count     = cnt_reg;
        case (grp_reg)
            FIT_EARLY: dpc.fit_len = mid;
            FIT_LATE:  dpc.fit_len = cnt_reg - mid;
            default:   dpc.fit_len = cnt_reg;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dpc.acc_clr = 1'b1;
                    if (cmd_op == OP_CLEAR)
                    begin
                        cnt_new     = '0;
                        oldest_next = '0;
                    end
                    else
                    begin
                        dpc.mem_we = 1'b1;
                        if (full)
                        begin
                            oldest_next = wrap(oldest_reg, CNT_W'(1));
                        end
                        else
                        begin
                            cnt_new = cnt_reg + 1'b1;
                        end
                    end
                    cnt_next   = cnt_new;
                    pos_next   = '0;
                    grp_next   = FIT_FULL;
                    ch_next    = '0;
                    state_next = (cnt_new < CNT_W'(MIN_FIT)) ? S_FIN1 : S_SCAN;
                end
            end
            S_SCAN:
            begin
                dpc.rd_en  = 1'b1;
                acc_v_next = 1'b1;
                if (pos_reg == cnt_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIT_A;
            end
            S_FIT_A:
            begin
                dpc.fit_a  = 1'b1;
                state_next = S_FIT_B;
            end
            S_FIT_B:
            begin
                dpc.fit_b  = 1'b1;
                state_next = S_FIT_C;
            end
            S_FIT_C:
            begin
                dpc.fit_c  = 1'b1;
                k_next     = QK_W'(QB - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                dpc.div_en = 1'b1;
                if (k_reg == '0)
                begin
                    dpc.div_last = 1'b1;
                    state_next   = S_FIT_A;
                    if (ch_reg == CH_W'(NUM_CH - 1))
                    begin
                        ch_next = '0;
                        if ((grp_reg == FIT_LATE) ||
                            (grp_reg == FIT_FULL && cnt_reg < CNT_W'(MIN_SPLIT)))
                        begin
                            state_next = S_FIN1;
                        end
                        else
                        begin
                            grp_next = (grp_reg == FIT_FULL) ? FIT_EARLY : FIT_LATE;
                        end
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                end
            end
            S_FIN1:
            begin
                dpc.fin1   = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                dpc.fin2   = 1'b1;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                dpc.fin3   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    dpc.load_out   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            oldest_reg    <= '0;
            pos_reg       <= '0;
            acc_v_reg     <= 1'b0;
            acc_pos_reg   <= '0;
            grp_reg       <= FIT_FULL;
            ch_reg        <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            oldest_reg    <= oldest_next;
            pos_reg       <= pos_next;
            acc_v_reg     <= acc_v_next;
            acc_pos_reg   <= acc_pos_next;
            grp_reg       <= grp_next;
            ch_reg        <= ch_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
        end
    end

    `WTST_ASSERT_ALWAYS(a_count_in_range, cnt_reg <= CNT_W'(HISTORY_DEPTH), "count beyond depth")
    `WTST_ASSERT_IMPL(a_oldest_moves_when_full, oldest_reg != '0, full, "oldest moved early")
    `WTST_ASSERT_NEXT(a_clear_empties, accept && cmd_op == OP_CLEAR, cnt_reg == '0, "clear kept samples")
    `WTST_ASSERT_IMPL(a_scan_in_window, state_reg == S_SCAN, pos_reg < cnt_reg, "scan past count")

endmodule

/* sv/wtst_dp.sv */
// Datapath of the slope tracker: history memory, sums, slope division and output register.
module wtst_dp
    import wtst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          dpc,
    input  cmd_t             cmd,
    input  logic             cfg_valid,
    input  logic [THR_W-1:0] cfg_data,
    output res_t             res
);

    logic [NUM_CH*SAMP_W-1:0] mem [HISTORY_DEPTH];
    logic [NUM_CH*SAMP_W-1:0] rd_data_reg;
    logic [THR_W-1:0]         thr_reg;

    logic signed [SY_W-1:0]  sy_f_reg  [NUM_CH];
    logic signed [SY_W-1:0]  sy_e_reg  [NUM_CH];
    logic signed [SY_W-1:0]  sy_l_reg  [NUM_CH];
    logic signed [SXY_W-1:0] sxy_f_reg [NUM_CH];
    logic signed [SXY_W-1:0] sxy_e_reg [NUM_CH];
    logic signed [SXY_W-1:0] sxy_l_reg [NUM_CH];

    logic signed [Q_W-1:0] qf_reg [NUM_CH];
    logic signed [Q_W-1:0] qe_reg [NUM_CH];
    logic signed [Q_W-1:0] ql_reg [NUM_CH];

    logic signed [SY_W-1:0]          sy_h_reg;
    logic signed [SXY_W-1:0]         sxy_h_reg;
    logic [R12_W-1:0]                r12_reg;
    logic [LM6_W-1:0]                lm6_reg;
    logic [LL_W-1:0]                 ll_reg;
    logic signed [SXY_W+R12_W:0]     p1_reg;
    logic signed [SY_W+LM6_W:0]      p2_reg;
    logic [DEN_W-1:0]                den_reg;
    logic [DIV_W-1:0]                rem_reg;
    logic [QB-1:0]                   quot_reg;
    logic                            qneg_reg;

    logic signed [SAMP_W-1:0] tr_reg [NUM_CH];
    logic [MAG_W-1:0]         mag_reg;
    logic                     oneg_reg;
    logic                     flag_reg;
    logic [MAG_W+RECIP_W-1:0] prod_reg;
    res_t                     res_reg;

    logic signed [SY_W-1:0]  sy_sel;
    logic signed [SXY_W-1:0] sxy_sel;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_mag;
    logic [DIV_W-1:0]        shifted;
    logic                    ge;
    logic [QB-1:0]           quot_new;
    logic signed [Q_W-1:0]   q_val;
    logic signed [SAMP_W+2:0] wsum;
    logic                    flag_now;
    logic [SAMP_W-1:0]       omag;

    function automatic logic signed [SAMP_W-1:0] sat10(input logic signed [Q_W-1:0] q);
        logic signed [Q_W+3:0] p;
        p = (Q_W+4)'(q) * $signed((Q_W+4)'(10));
        if (p > $signed((Q_W+4)'(32767)))
        begin
            p = $signed((Q_W+4)'(32767));
        end
        else if (p < -$signed((Q_W+4)'(32768)))
        begin
            p = -$signed((Q_W+4)'(32768));
        end
        return p[SAMP_W-1:0];
    endfunction

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (dpc.mem_we)
        begin
            mem[dpc.mem_waddr] <= {cmd.sample_valence, cmd.sample_arousal,
                                   cmd.sample_dominance};
        end
        if (dpc.rd_en)
        begin
            rd_data_reg <= mem[dpc.rd_addr];
        end
    end

    // Running sums over the window and its two halves.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            logic signed [SAMP_W-1:0]    y;
            logic signed [SAMP_W+CNT_W:0] xy;
            logic signed [SAMP_W+CNT_W:0] xy_l;
            y    = rd_data_reg[(NUM_CH-1-c)*SAMP_W +: SAMP_W];
            xy   = y * $signed({1'b0, dpc.acc_pos});
            xy_l = y * $signed({1'b0, dpc.acc_pos - dpc.mid});
            if (dpc.acc_clr)
            begin
                sy_f_reg[c]  <= '0;
                sy_e_reg[c]  <= '0;
                sy_l_reg[c]  <= '0;
                sxy_f_reg[c] <= '0;
                sxy_e_reg[c] <= '0;
                sxy_l_reg[c] <= '0;
            end
            else if (dpc.acc_en)
            begin
                sy_f_reg[c]  <= sy_f_reg[c] + SY_W'(y);
                sxy_f_reg[c] <= sxy_f_reg[c] + SXY_W'(xy);
                if (dpc.acc_pos < dpc.mid)
                begin
                    sy_e_reg[c]  <= sy_e_reg[c] + SY_W'(y);
                    sxy_e_reg[c] <= sxy_e_reg[c] + SXY_W'(xy);
                end
                else
                begin
                    sy_l_reg[c]  <= sy_l_reg[c] + SY_W'(y);
                    sxy_l_reg[c] <= sxy_l_reg[c] + SXY_W'(xy_l);
                end
            end
        end
    end

    always_comb
    begin
        case (dpc.grp)
            FIT_EARLY:
            begin
                sy_sel  = sy_e_reg[dpc.ch];
                sxy_sel = sxy_e_reg[dpc.ch];
            end
            FIT_LATE:
            begin
                sy_sel  = sy_l_reg[dpc.ch];
                sxy_sel = sxy_l_reg[dpc.ch];
            end
            default:
            begin
                sy_sel  = sy_f_reg[dpc.ch];
                sxy_sel = sxy_f_reg[dpc.ch];
            end
        endcase
    end

    // Scaled slope: 12*(n*Sxy - Sx*Sy) over n^2*(n^2-1).
    assign num     = NUM_W'(p1_reg) - NUM_W'(p2_reg);
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign shifted = DIV_W'(den_reg) << dpc.div_k;
    assign ge      = (rem_reg >= shifted);
    assign quot_new = quot_reg | (QB'(ge) << dpc.div_k);
    assign q_val   = qneg_reg ? -$signed(Q_W'(quot_new)) : $signed(Q_W'(quot_new));

    always_ff @(posedge clk)
    begin
        if (dpc.fit_a)
        begin
            sy_h_reg  <= sy_sel;
            sxy_h_reg <= sxy_sel;
            r12_reg   <= (R12_W'(dpc.fit_len) << 3) + (R12_W'(dpc.fit_len) << 2);
            lm6_reg   <= LM6_W'(dpc.fit_len) *
                         ((LM6_W'(dpc.fit_len - 1'b1) << 2) +
                          (LM6_W'(dpc.fit_len - 1'b1) << 1));
            ll_reg    <= LL_W'(dpc.fit_len) * LL_W'(dpc.fit_len);
        end
        if (dpc.fit_b)
        begin
            p1_reg  <= sxy_h_reg * $signed({1'b0, r12_reg});
            p2_reg  <= sy_h_reg * $signed({1'b0, lm6_reg});
            den_reg <= DEN_W'(ll_reg) * DEN_W'(ll_reg - 1'b1);
        end
        if (dpc.fit_c)
        begin
            rem_reg  <= DIV_W'(num_mag);
            qneg_reg <= num[NUM_W-1];
            quot_reg <= '0;
        end
        if (dpc.div_en)
        begin
            quot_reg <= quot_new;
            if (ge)
            begin
                rem_reg <= rem_reg - shifted;
            end
        end
    end

    // Slope results, zero unless a fit ran for this item.
    always_ff @(posedge clk)
    begin
        if (dpc.acc_clr)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                qf_reg[c] <= '0;
                qe_reg[c] <= '0;
                ql_reg[c] <= '0;
            end
        end
        else if (dpc.div_en && dpc.div_last)
        begin
            case (dpc.grp)
                FIT_EARLY: qe_reg[dpc.ch] <= q_val;
                FIT_LATE:  ql_reg[dpc.ch] <= q_val;
                default:   qf_reg[dpc.ch] <= q_val;
            endcase
        end
    end

    assign wsum = ((SAMP_W+3)'(tr_reg[0]) <<< 1) + ((SAMP_W+3)'(tr_reg[1]) <<< 1) +
                  (SAMP_W+3)'(tr_reg[2]);

    always_comb
    begin
        flag_now = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            logic signed [Q_W:0] d;
            logic [Q_W:0]        dm;
            d  = (Q_W+1)'(ql_reg[c]) - (Q_W+1)'(qe_reg[c]);
            dm = d[Q_W] ? (Q_W+1)'(-d) : (Q_W+1)'(d);
            if (dm > (Q_W+1)'(thr_reg))
            begin
                flag_now = 1'b1;
            end
        end
    end

    assign omag = prod_reg[RECIP_SH +: SAMP_W];

    always_ff @(posedge clk)
    begin
        if (dpc.fin1)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                tr_reg[c] <= sat10(qf_reg[c]);
            end
        end
        if (dpc.fin2)
        begin
            oneg_reg <= wsum[SAMP_W+2];
            mag_reg  <= wsum[SAMP_W+2] ? MAG_W'(-wsum) : MAG_W'(wsum);
            flag_reg <= flag_now;
        end
        if (dpc.fin3)
        begin
            // Divide by five through the reciprocal; exact for magnitudes below 2^18.
            prod_reg <= (MAG_W+RECIP_W)'(mag_reg) * (MAG_W+RECIP_W)'(RECIP5);
        end
        if (dpc.load_out)
        begin
            res_reg.valence_trend   <= tr_reg[0];
            res_reg.arousal_trend   <= tr_reg[1];
            res_reg.dominance_trend <= tr_reg[2];
            res_reg.overall_trend   <= oneg_reg ? SAMP_W'(16'd0 - omag) : omag;
            res_reg.trend_changed   <= flag_reg;
            res_reg.sample_count    <= CNT_OUT_W'(dpc.count);
        end
    end

    assign res = res_reg;

endmodule

/* sv/windowed_trend_slope_tracker_core.sv */
// Top level of the windowed least-squares trend slope tracker.
//
//  channel  signals                     direction  moves
//  cmd      cmd_valid/cmd_ready/cmd     in         add-sample or clear transaction
//  res      res_valid/res_ready/res     out        trends, change flag, sample count
//  cfg      cfg_valid/cfg_ready/cfg_data in        change threshold write
//
// One command at a time. With n samples held after the command, a transaction runs
// 9 slope fits for n >= 6 and 3 for n of 2 to 5; a clear, or n below 2, runs none.
// The scan reads one history entry per cycle through the memory's registered read port;
// each fit then runs a restoring divider that resolves one quotient bit per cycle.
// Reset is asynchronous, active low; it empties the history and restores the threshold.
// A finished result waits in the output register while the next command is accepted;
// the sequencer stalls before loading the following result until res is taken.
module windowed_trend_slope_tracker_core
    import wtst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    dp_cmd_t dpc;

    // Threshold writes go straight into a register, so never hold the config channel.
    assign cfg_ready = 1'b1;

    // Sequence the history update, the window scan and each slope fit.
    wtst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_op    (cmd.op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .dpc       (dpc)
    );

    // Hold the samples, accumulate sums, divide and form the result.
    wtst_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dpc       (dpc),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .res       (res)
    );

endmodule

/* tb/wtst_checker.sv */
// Checker: watches the slope tracker channels, predicts each result and compares.
module wtst_checker
    import wtst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_ready,
    input  cmd_t             cmd,
    input  logic             res_valid,
    input  logic             res_ready,
    input  res_t             res,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int EXP_DEPTH = 4;

    logic signed [SAMP_W-1:0] window_mem [HISTORY_DEPTH][NUM_CH];
    int unsigned oldest_slot;
    int unsigned held;
    logic [THR_W-1:0] threshold;
    res_t expected_trends [EXP_DEPTH];
    int unsigned wr_count;
    int unsigned rd_count;

    assign pending = int'(wr_count - rd_count);

    function automatic longint window_slope(int unsigned start, int unsigned len, int ch);
        longint n, sx, sy, sxy, sxx, num, den, y;
        n = len; sx = 0; sy = 0; sxy = 0; sxx = 0;
        if (len < 2) return 0;
        for (int unsigned i = 0; i < len; i++)
        begin
            y = window_mem[(oldest_slot + start + i) % HISTORY_DEPTH][ch];
            sx += i; sy += y; sxy += i * y; sxx += i * i;
        end
        num = n * sxy - sx * sy;
        den = n * sxx - sx * sx;
        if (den <= 0) return 0;
        return num / den;
    endfunction

    function automatic res_t predict_trend(cmd_t c);
        res_t r;
        longint s, early, late, d;
        longint tr [NUM_CH];
        int unsigned mid;
        int unsigned slot;
        r = '0;
        if (c.op == OP_CLEAR)
        begin
            held = 0; oldest_slot = 0;
        end
        else
        begin
            if (held >= HISTORY_DEPTH)
            begin
                slot = oldest_slot;
                oldest_slot = (oldest_slot + 1) % HISTORY_DEPTH;
            end
            else
            begin
                slot = (oldest_slot + held) % HISTORY_DEPTH;
                held++;
            end
            window_mem[slot][0] = c.sample_valence;
            window_mem[slot][1] = c.sample_arousal;
            window_mem[slot][2] = c.sample_dominance;
        end
        for (int ch = 0; ch < NUM_CH; ch++) tr[ch] = 0;
        if (held >= MIN_FIT)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                s = window_slope(0, held, ch) * 10;
                tr[ch] = (s > 32767) ? 32767 : (s < -32768) ? -32768 : s;
            end
        end
        r.valence_trend = SAMP_W'(tr[0]);
        r.arousal_trend = SAMP_W'(tr[1]);
        r.dominance_trend = SAMP_W'(tr[2]);
        r.overall_trend = SAMP_W'((2 * tr[0] + 2 * tr[1] + tr[2]) / 5);
        if (held >= MIN_SPLIT)
        begin
            mid = held / 2;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                early = window_slope(0, mid, ch);
                late = window_slope(mid, held - mid, ch);
                d = late - early;
                if (d < 0) d = -d;
                if (d > threshold) r.trend_changed = 1'b1;
            end
        end
        r.sample_count = held[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            held = 0; oldest_slot = 0; threshold = THR_RESET;
            fail_count = 0;
            wr_count = 0;
            rd_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) threshold = cfg_data;
            if (cmd_valid && cmd_ready)
            begin
                if (wr_count - rd_count >= EXP_DEPTH)
                    report_mismatch("too many outstanding", int'(wr_count - rd_count),
                                    EXP_DEPTH);
                expected_trends[wr_count % EXP_DEPTH] = predict_trend(cmd);
                wr_count++;
            end
            if (res_valid && res_ready)
            begin
                if (wr_count == rd_count)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = expected_trends[rd_count % EXP_DEPTH];
                    rd_count++;
                    if (res.valence_trend !== want.valence_trend)
                        report_mismatch("valence_trend", res.valence_trend, want.valence_trend);
                    if (res.arousal_trend !== want.arousal_trend)
                        report_mismatch("arousal_trend", res.arousal_trend, want.arousal_trend);
                    if (res.dominance_trend !== want.dominance_trend)
                        report_mismatch("dominance_trend", res.dominance_trend,
                                        want.dominance_trend);
                    if (res.overall_trend !== want.overall_trend)
                        report_mismatch("overall_trend", res.overall_trend, want.overall_trend);
                    if (res.trend_changed !== want.trend_changed)
                        report_mismatch("trend_changed", res.trend_changed, want.trend_changed);
                    if (res.sample_count !== want.sample_count)
                        report_mismatch("sample_count", res.sample_count, want.sample_count);
                end
            end
        end
    end

endmodule

/* tb/tb_windowed_trend_slope_tracker_core.sv */
// Testbench top: drives commands, threshold writes and result ready, gives the verdict.
module tb_windowed_trend_slope_tracker_core
    import wtst_pkg::*;
();

    logic             clk;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_t             cmd;
    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               send_idle_pct;
    int               recv_idle_pct;
    longint           cycle_count = 0;

    // Limit on the whole run, set far above what the transactions and stalls need.
    localparam longint CYCLE_LIMIT = 2000000;

    windowed_trend_slope_tracker_core dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    wtst_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: end the run with a failure once the cycle count passes the limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: drop ready at random for the current idle share.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one transaction; hold valid and payload until accepted, then drop valid.
    task automatic send_cmd(logic op, logic [15:0] v, logic [15:0] a, logic [15:0] d);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        cmd_valid <= 1'b1;
        cmd <= '{op: op, sample_valence: v, sample_arousal: a, sample_dominance: d};
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        cmd_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // Write the threshold only once every result is back and the block has settled.
    task automatic write_threshold(logic [THR_W-1:0] value);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly samples that fill and wrap the window, now and then a clear.
    task automatic random_run(int count);
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 3)
                send_cmd(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
            else if (kind < 50)
            begin
                // Smooth ramp with noise so slopes stay in range.
                send_cmd(OP_ADD, 16'(i * 37 + $urandom_range(60)),
                         16'(-i * 11 + $urandom_range(600)), 16'($urandom_range(400)));
            end
            else
                send_cmd(OP_ADD, rand_sample(), rand_sample(), rand_sample());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 15;
        recv_idle_pct = 61;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: clear on empty, one sample, extremes, alternating rails, a 14-sample ramp.
        send_cmd(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(OP_ADD, 16'h8000, 16'h7FFF, 16'h0000);
        send_cmd(OP_ADD, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_cmd(OP_ADD, 16'h8000, 16'h7FFF, 16'h0001);
        send_cmd(OP_ADD, 16'h7FFF, 16'h8000, 16'h8000);
        send_cmd(OP_ADD, 16'h0000, 16'h0000, 16'h7FFF);
        send_cmd(OP_ADD, 16'h0100, 16'hFF00, 16'h5555);
        send_cmd(OP_ADD, 16'h0200, 16'hFE00, 16'hAAAA);
        send_cmd(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < 14; i++)
            send_cmd(OP_ADD, 16'(i * 1000), 16'(-i * 7), 16'(i * i * 150));

        write_threshold('0);
        random_run(150);
        write_threshold(15'h7FFF);
        random_run(150);
        send_idle_pct = 61;
        recv_idle_pct = 15;
        write_threshold(15'd100);
        random_run(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(15'($urandom));
        random_run(300);

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
